// File: hw/rtl/ppa_pkg.sv
// Shared codes and constants for the port pool allocator.
package ppa_pkg;

   // Kind of a request beat.
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FAIL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BASE_PORT   = 2'd0;
   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [1:0] CSR_STRIDE_TWO  = 2'd2;

   // Entry codes: free, in use, first cooldown step. Bit two marks cooling.
   localparam logic [2:0] ENTRY_FREE       = 3'd0;
   localparam logic [2:0] ENTRY_USED       = 3'd1;
   localparam logic [2:0] ENTRY_COOL_START = 3'd4;
   localparam int         ENTRY_COOL_BIT   = 2;

   // Number of full passes a probe walk makes before it gives up.
   localparam logic [2:0] PASS_LIMIT = 3'd5;

   // Width of port numbers and hints.
   localparam int PORT_W = 16;

endpackage

// File: hw/rtl/ppa_mod_unit.sv
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
module ppa_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppa_pkg::PORT_W-1:0]   dividend,
   input  logic [ppa_pkg::PORT_W-1:0]   divisor,
   output logic                         done,
   output logic [ppa_pkg::PORT_W-1:0]   remainder
);

   localparam int W  = ppa_pkg::PORT_W;
   localparam int CW = $clog2(W + 1);

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W:0]    trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial     = {rem_ff, dvd_ff[W-1]};
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = CW'(W);
         dvd_in    = dividend;
         dsr_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         dvd_in   = {dvd_ff[W-2:0], 1'b0};
         count_in = count_ff - CW'(1);
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         if (count_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/port_pool_allocator.sv
// Port pool allocator: entry table memory, probe sequencer and configuration.
//
//   Channel    Handshake          Payload
//   request    start / busy       req_kind, req_start_hint, req_port_in
//   response   rsp_valid strobe   rsp_status, rsp_port_out
//   csr        csr_write          csr_index, csr_data
//
// A full-pool request or an out-of-range release answers in the cycle after its beat;
// other releases pass through a read state and a check state before they answer.
// A request first reduces its hint in the bit-serial remainder unit, then probes entries
// in turn, reading each one and writing back those whose code changes.
// After reset a clearing pass frees every entry with busy high.
// The receiver cannot stall: each result is held for one cycle only.
module port_pool_allocator #(
   parameter int MAX_ENTRIES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [15:0] req_start_hint,
   input  logic [15:0] req_port_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_port_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = IW + 1;

   typedef enum logic [6:0] {
      ST_CLEAR     = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_DIVIDE    = 7'b0000100,
      ST_PROBE_RD  = 7'b0001000,
      ST_PROBE_CHK = 7'b0010000,
      ST_REL_RD    = 7'b0100000,
      ST_REL_CHK   = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] tries_ff, tries_in;
   logic [2:0]    pass_ff, pass_in;
   logic [CW-1:0] used_count_ff, used_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_port_ff, rsp_port_in;

   logic [15:0]   base_port_ff;
   logic [14:0]   entry_count_ff;
   logic          stride_two_ff;

   logic [2:0]    entry_mem [MAX_ENTRIES];
   logic [2:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr;
   logic [2:0]    mem_wdata;

   logic          div_start, div_done;
   logic [15:0]   div_rem;

   logic [15:0]   count_wide;
   logic [CW-1:0] eff_count;
   logic [CW-1:0] idx_inc, tries_inc;
   logic [IW-1:0] idx_adv;
   logic [15:0]   grant_port;
   logic [15:0]   rel_offset, rel_index;
   logic          rel_below, rel_beyond;

   // Configuration registers, written whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_port_ff   <= '0;
         entry_count_ff <= 15'(MAX_ENTRIES);
         stride_two_ff  <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            ppa_pkg::CSR_BASE_PORT:   base_port_ff   <= csr_data;
            ppa_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_data[14:0];
            ppa_pkg::CSR_STRIDE_TWO:  stride_two_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective entry count: zero acts as one, large values clamp to the table.
   always_comb begin
      count_wide = {1'b0, entry_count_ff};
      if (count_wide == 16'd0) begin
         eff_count = CW'(1);
      end else if (count_wide > 16'(MAX_ENTRIES)) begin
         eff_count = CW'(MAX_ENTRIES);
      end else begin
         eff_count = CW'(count_wide);
      end
   end

   // Probe step helpers and the granted port number.
   assign idx_inc    = {1'b0, idx_ff} + CW'(1);
   assign idx_adv    = (idx_inc >= eff_count) ? '0 : idx_inc[IW-1:0];
   assign tries_inc  = tries_ff + CW'(1);
   assign grant_port = 16'(17'(base_port_ff) +
                           (stride_two_ff ? 17'({idx_ff, 1'b0}) : 17'(idx_ff)));

   // Release bounds check on the incoming port.
   assign rel_below  = req_port_in < base_port_ff;
   assign rel_offset = req_port_in - base_port_ff;
   assign rel_index  = stride_two_ff ? {1'b0, rel_offset[15:1]} : rel_offset;
   assign rel_beyond = {1'b0, rel_index} >= 17'(eff_count);

   assign div_start = (state_ff == ST_IDLE) && start && (req_kind == ppa_pkg::KIND_REQUEST)
                      && (used_count_ff < eff_count);

   // Remainder of the hint by the entry count.
   ppa_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_start_hint),
      .divisor   (16'(eff_count)),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Sequencer: clearing pass, idle, remainder wait, probe walk and release.
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      idx_in        = idx_ff;
      tries_in      = tries_ff;
      pass_in       = pass_ff;
      used_count_in = used_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = ppa_pkg::ENTRY_FREE;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == IW'(MAX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_kind == ppa_pkg::KIND_REQUEST) begin
                  if (used_count_ff >= eff_count) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ppa_pkg::STATUS_FAIL;
                     rsp_port_in   = '0;
                  end else begin
                     state_in = ST_DIVIDE;
                  end
               end else if (rel_below || rel_beyond) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ppa_pkg::STATUS_RANGE;
                  rsp_port_in   = '0;
               end else begin
                  idx_in   = rel_index[IW-1:0];
                  state_in = ST_REL_RD;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               idx_in   = div_rem[IW-1:0];
               tries_in = '0;
               pass_in  = '0;
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            mem_re   = 1'b1;
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (rd_data_ff == ppa_pkg::ENTRY_FREE) begin
               // Free entry: take it.
               mem_we        = 1'b1;
               mem_wdata     = ppa_pkg::ENTRY_USED;
               used_count_in = used_count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ppa_pkg::STATUS_OK;
               rsp_port_in   = grant_port;
               state_in      = ST_IDLE;
            end else begin
               // Cooling entries age one step as the walk passes them.
               if (rd_data_ff[ppa_pkg::ENTRY_COOL_BIT]) begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff + 3'd1;
               end
               idx_in   = idx_adv;
               state_in = ST_PROBE_RD;
               if (tries_inc == eff_count) begin
                  tries_in = '0;
                  if (pass_ff == ppa_pkg::PASS_LIMIT - 3'd1) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ppa_pkg::STATUS_FAIL;
                     rsp_port_in   = '0;
                     state_in      = ST_IDLE;
                  end else begin
                     pass_in = pass_ff + 3'd1;
                  end
               end else begin
                  tries_in = tries_inc;
               end
            end
         end
         ST_REL_RD: begin
            mem_re   = 1'b1;
            state_in = ST_REL_CHK;
         end
         ST_REL_CHK: begin
            rsp_valid_in = 1'b1;
            rsp_port_in  = '0;
            state_in     = ST_IDLE;
            // Codes one to three count as in use.
            if ((rd_data_ff != ppa_pkg::ENTRY_FREE) &&
                !rd_data_ff[ppa_pkg::ENTRY_COOL_BIT]) begin
               mem_we        = 1'b1;
               mem_wdata     = ppa_pkg::ENTRY_COOL_START;
               rsp_status_in = ppa_pkg::STATUS_OK;
               if (used_count_ff != '0) begin
                  used_count_in = used_count_ff - CW'(1);
               end
            end else begin
               rsp_status_in = ppa_pkg::STATUS_FAIL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tries_ff      <= tries_in;
      pass_ff       <= pass_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
   end

   // Entry table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[idx_ff];
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_port_out = rsp_port_ff;

   // The live count never exceeds the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CW'(MAX_ENTRIES))
      else $error("used count beyond table size");

   // A request against a full pool fails on the next cycle.
   a_full_fails: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == ppa_pkg::KIND_REQUEST) &&
       (used_count_ff >= eff_count))
      |=> (rsp_valid && (rsp_status == ppa_pkg::STATUS_FAIL)))
      else $error("full pool request did not fail");

   // The table is never written while the block is idle.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("table write while idle");

   // The remainder unit finishes only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder finished outside its wait state");

endmodule

// File: verif/port_pool_allocator_test.sv
// Self-checking testbench for the port pool allocator, with driver, monitor and port predictor.
module port_pool_allocator_test;

   localparam int          POOL_DEPTH   = 16384;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          SETTLE       = 8;
   localparam int          TAIL_CYCLES  = 64;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;

   typedef enum logic [1:0] {OP_BEAT, OP_CSR, OP_PAUSE} op_action_type;

   typedef struct {
      op_action_type action;
      logic          kind;
      logic [15:0]   hint;
      logic [15:0]   port;
      logic [1:0]    csr_idx;
      logic [15:0]   csr_val;
      int unsigned   gap_pct;
   } pending_op_type;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] port_out;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = ppa_pkg::KIND_REQUEST;
   logic [15:0] req_start_hint = '0;
   logic [15:0] req_port_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_port_out;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = ppa_pkg::CSR_BASE_PORT;
   logic [15:0] csr_data = '0;

   // Stimulus queue, expected answers and bookkeeping.
   pending_op_type pending_ops[$];
   answer_type     expected_answers[$];
   int             answers_owed = 0;
   int             quiet_cycles = 0;
   bit             all_sent = 1'b0;
   int             mismatch_count = 0;
   int unsigned    cycle_count = 0;

   // Predicted pool contents and register copies.
   logic [2:0]  pool_state [POOL_DEPTH];
   int unsigned live_count;
   logic [15:0] base_reg;
   logic [14:0] count_reg;
   logic        stride_reg;

   port_pool_allocator #(.MAX_ENTRIES(POOL_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_start_hint (req_start_hint),
      .req_port_in    (req_port_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_port_out   (rsp_port_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // A count of zero behaves as one entry, and counts above the table size are clamped.
   function automatic int unsigned effective_entries(input int unsigned count_value);
      if (count_value == 0) return 1;
      if (count_value > POOL_DEPTH) return POOL_DEPTH;
      return count_value;
   endfunction

   // Works out the answer to one beat and updates the predicted pool.
   function automatic answer_type predict_answer(input logic kind, input logic [15:0] hint,
                                                 input logic [15:0] port);
      int unsigned n, idx, offset, tries, pass_no;
      answer_type  ans;
      n = effective_entries(count_reg);
      ans.status = ppa_pkg::STATUS_FAIL;
      ans.port_out = '0;
      if (kind == ppa_pkg::KIND_REQUEST) begin
         // A full pool fails at once; otherwise probe upward, aging cooling entries.
         if (live_count < n) begin
            idx = hint % n;
            for (pass_no = 0;
                 pass_no < ppa_pkg::PASS_LIMIT && ans.status != ppa_pkg::STATUS_OK;
                 pass_no++) begin
               tries = 0;
               while (tries < n && pool_state[idx] != ppa_pkg::ENTRY_FREE) begin
                  if (pool_state[idx][ppa_pkg::ENTRY_COOL_BIT])
                     pool_state[idx] = pool_state[idx] + 3'd1;
                  tries++;
                  idx = (idx + 1 >= n) ? 0 : idx + 1;
               end
               if (tries < n) begin
                  ans.status = ppa_pkg::STATUS_OK;
                  ans.port_out = 16'(base_reg + (stride_reg ? 2 * idx : idx));
                  pool_state[idx] = ppa_pkg::ENTRY_USED;
                  live_count++;
               end
            end
         end
      end else begin
         // A release must land inside the pool and hit an entry that is in use.
         ans.status = ppa_pkg::STATUS_RANGE;
         if (port >= base_reg) begin
            offset = port - base_reg;
            if (stride_reg) offset = offset >> 1;
            if (offset < n) begin
               if (pool_state[offset] != ppa_pkg::ENTRY_FREE &&
                   !pool_state[offset][ppa_pkg::ENTRY_COOL_BIT]) begin
                  pool_state[offset] = ppa_pkg::ENTRY_COOL_START;
                  if (live_count > 0) live_count--;
                  ans.status = ppa_pkg::STATUS_OK;
               end else begin
                  ans.status = ppa_pkg::STATUS_FAIL;
               end
            end
         end
      end
      return ans;
   endfunction

   task automatic add_beat(input logic kind, input logic [15:0] hint, input logic [15:0] port,
                           input int unsigned gap);
      pending_op_type op;
      op.action = OP_BEAT;
      op.kind = kind;
      op.hint = hint;
      op.port = port;
      op.csr_idx = ppa_pkg::CSR_BASE_PORT;
      op.csr_val = '0;
      op.gap_pct = gap;
      pending_ops.push_back(op);
   endtask

   task automatic add_csr(input logic [1:0] idx, input logic [15:0] value);
      pending_op_type op;
      op.action = OP_CSR;
      op.kind = ppa_pkg::KIND_REQUEST;
      op.hint = '0;
      op.port = '0;
      op.csr_idx = idx;
      op.csr_val = value;
      op.gap_pct = 0;
      pending_ops.push_back(op);
   endtask

   task automatic add_pause();
      pending_op_type op;
      op.action = OP_PAUSE;
      op.kind = ppa_pkg::KIND_REQUEST;
      op.hint = '0;
      op.port = '0;
      op.csr_idx = ppa_pkg::CSR_BASE_PORT;
      op.csr_val = '0;
      op.gap_pct = 0;
      pending_ops.push_back(op);
   endtask

   // Driver: issues beats with random gaps; register writes and pauses wait for a quiet block.
   always @(posedge clock) begin : drive_beats
      bit             raise;
      bit             write_now;
      pending_op_type op;
      raise = 1'b0;
      write_now = 1'b0;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && busy) begin
            raise = 1'b1;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops[0];
            case (op.action)
               OP_BEAT: begin
                  if ($urandom_range(99) >= op.gap_pct) begin
                     raise = 1'b1;
                     req_kind <= op.kind;
                     req_start_hint <= op.hint;
                     req_port_in <= op.port;
                     void'(pending_ops.pop_front());
                  end
               end
               default: begin
                  if (!start && quiet_cycles >= SETTLE) begin
                     if (op.action == OP_CSR) begin
                        write_now = 1'b1;
                        csr_index <= op.csr_idx;
                        csr_data <= op.csr_val;
                     end
                     void'(pending_ops.pop_front());
                  end
               end
            endcase
         end
         if (!start && !busy && answers_owed == 0)
            quiet_cycles <= quiet_cycles + 1;
         else
            quiet_cycles <= 0;
      end
      start <= raise;
      csr_write <= write_now;
      all_sent <= !reset && pending_ops.size() == 0 && !raise;
   end

   // Monitor: checks each result beat, tracks register writes, predicts accepted beats.
   always @(posedge clock) begin : watch_ports
      answer_type want;
      bit         took;
      bit         got;
      if (reset) begin
         foreach (pool_state[i]) pool_state[i] = ppa_pkg::ENTRY_FREE;
         live_count = 0;
         base_reg = '0;
         count_reg = 15'(POOL_DEPTH);
         stride_reg = 1'b1;
         answers_owed <= 0;
      end else begin
         took = 1'b0;
         got = 1'b0;
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected result beat: rsp_status %0d, rsp_port_out %0d",
                      rsp_status, rsp_port_out);
               mismatch_count++;
            end else begin
               got = 1'b1;
               want = expected_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_port_out !== want.port_out) begin
                  $error("rsp_port_out: expected %0d, actual %0d", want.port_out, rsp_port_out);
                  mismatch_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               ppa_pkg::CSR_BASE_PORT:   base_reg = csr_data;
               ppa_pkg::CSR_ENTRY_COUNT: count_reg = csr_data[14:0];
               ppa_pkg::CSR_STRIDE_TWO:  stride_reg = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            took = 1'b1;
            expected_answers.push_back(predict_answer(req_kind, req_start_hint, req_port_in));
         end
         answers_owed <= answers_owed + int'(took) - int'(got);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin : run_test
      int unsigned made, phase_len, n_eff, span, step, gap, pick, r, gen_count, gen_base;
      logic        gen_stride;
      logic [15:0] port;

      // Directed: default registers, extremes of hint and port, odd offset, not in use.
      add_beat(ppa_pkg::KIND_REQUEST, 16'h0000, 16'hFFFF, 22);
      add_beat(ppa_pkg::KIND_REQUEST, 16'hFFFF, 16'h0000, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'h0000, 16'hFFFF, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'h0000, 16'd32767, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'hFFFF, 16'd32766, 22);
      add_pause();

      // Directed: a three-entry pool at port 100; fill it, range errors, cooldown walk.
      add_csr(ppa_pkg::CSR_BASE_PORT, 16'd100);
      add_csr(ppa_pkg::CSR_ENTRY_COUNT, 16'd3);
      add_csr(ppa_pkg::CSR_STRIDE_TWO, 16'd0);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd0, 16'd0, 22);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd1, 16'd0, 22);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd2, 16'd0, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd99, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd103, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd101, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd101, 22);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd1, 16'd0, 22);

      // Directed: a zero count acts as one entry.
      add_csr(ppa_pkg::CSR_ENTRY_COUNT, 16'd0);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd5, 16'd0, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd100, 22);

      // Directed: oversized count, top base port so the granted port wraps.
      add_csr(ppa_pkg::CSR_ENTRY_COUNT, 16'hFFFF);
      add_csr(ppa_pkg::CSR_BASE_PORT, 16'hFFFF);
      add_beat(ppa_pkg::KIND_REQUEST, 16'd1, 16'd0, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'd0, 22);
      add_beat(ppa_pkg::KIND_RELEASE, 16'd0, 16'hFFFF, 22);

      // Random phases: new registers each phase, mostly small pools so they fill and cool.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 8) gen_count = 0;
         else if (pick < 16) gen_count = POOL_DEPTH;
         else if (pick < 22) gen_count = $urandom_range(POOL_DEPTH + 1, 32767);
         else gen_count = $urandom_range(1, 40);
         pick = $urandom_range(99);
         if (pick < 15) gen_base = 0;
         else if (pick < 25) gen_base = 65535;
         else if (pick < 45) gen_base = $urandom_range(65400, 65535);
         else gen_base = $urandom_range(0, 65535);
         gen_stride = 1'($urandom_range(1));
         add_csr(ppa_pkg::CSR_ENTRY_COUNT, {1'($urandom_range(1)), 15'(gen_count)});
         add_csr(ppa_pkg::CSR_BASE_PORT, 16'(gen_base));
         add_csr(ppa_pkg::CSR_STRIDE_TWO, {15'($urandom_range(0, 32767)), gen_stride});

         n_eff = effective_entries(gen_count);
         span = (n_eff > 64) ? 64 : n_eff;
         step = gen_stride ? 2 : 1;
         phase_len = (n_eff > 64) ? 30 : 80;
         repeat (phase_len) begin
            if (made < RANDOM_ITEMS / 3) gap = 22;
            else if (made < 2 * RANDOM_ITEMS / 3) gap = 56;
            else gap = 0;
            if ($urandom_range(99) < 2) add_pause();
            if ($urandom_range(99) < 55) begin
               // Requests; large pools keep hints low so releases find live entries.
               if (n_eff > 64 && $urandom_range(99) < 70)
                  add_beat(ppa_pkg::KIND_REQUEST, 16'($urandom_range(0, 63)),
                           16'($urandom_range(0, 65535)), gap);
               else
                  add_beat(ppa_pkg::KIND_REQUEST, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), gap);
            end else begin
               // Releases: mostly pool ports, some past the end, some anywhere.
               r = $urandom_range(99);
               if (r < 70)
                  port = 16'(gen_base + step * $urandom_range(0, span - 1) +
                             (gen_stride ? $urandom_range(1) : 0));
               else if (r < 85)
                  port = 16'(gen_base + step * (n_eff + $urandom_range(0, 3)));
               else
                  port = 16'($urandom_range(0, 65535));
               add_beat(ppa_pkg::KIND_RELEASE, 16'($urandom_range(0, 65535)), port, gap);
            end
            made++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait until every beat is sent and answered, then let stray results show up.
      do @(posedge clock); while (!all_sent || answers_owed != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
